### design/tcs_pkg.sv
// Shared types and constants for the Taylor-series cosine and sine block.
// Holds the Q.40 formats, the angle constants and the reciprocal table.
// No dependencies.
package tcs_pkg;

	localparam int FRAC = 40;
	localparam int MAX_TERMS = 15;
	localparam int TERM_TABLE = 20;
	localparam int N_CELLS = (MAX_TERMS < TERM_TABLE) ? MAX_TERMS : TERM_TABLE;

	localparam int ANGLE_W = 32;
	localparam int ANG_FRAC = 28;
	localparam int ANG_SHIFT = FRAC - ANG_FRAC;
	localparam int X_W = 46;
	localparam int XM_W = 42;
	localparam int XMH_W = XM_W / 2;
	localparam int XSQ_W = 44;
	localparam int XH_W = XSQ_W / 2;
	localparam int MAG_W = 44;
	localparam int U_W = 47;
	localparam int RCP_W = 40;
	localparam int RH_W = RCP_W / 2;
	localparam int SUM_W = 46;
	localparam int VAL_W = 32;
	localparam int VAL_FRAC = 30;
	localparam int OUT_SHIFT = FRAC - VAL_FRAC;
	localparam int SH_W = SUM_W - OUT_SHIFT;
	localparam int R_W = VAL_FRAC + 1;

	localparam int FRONT_STAGES = 5;
	localparam int CELL_STAGES = 4;
	localparam int OUT_STAGES = 3;
	localparam int LATENCY = FRONT_STAGES + CELL_STAGES * N_CELLS + OUT_STAGES;

	localparam logic signed [X_W-1:0] PI_Q40 = X_W'(64'h3243F6A8886);
	localparam logic signed [X_W-1:0] TWO_PI_Q40 = X_W'(64'h6487ED5110B);
	localparam logic signed [X_W-1:0] HALF_PI_Q40 = X_W'(64'h1921FB54443);
	localparam logic signed [X_W-1:0] NEG_PI_Q40 = -PI_Q40;
	localparam logic signed [X_W-1:0] NEG_THREE_PI_Q40 = -PI_Q40 - TWO_PI_Q40;
	localparam logic signed [X_W-1:0] FOUR_PI_Q40 = TWO_PI_Q40 + TWO_PI_Q40;

	localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC;
	localparam logic [SH_W-1:0] VAL_MAX = SH_W'(1) << VAL_FRAC;
	localparam logic LAST_NEG = ((N_CELLS % 2) == 1);

	localparam logic [63:0] RCP_ONE = 64'd1 << FRAC;

	localparam logic [RCP_W-1:0] RECIP_TAB [TERM_TABLE] = '{
		RCP_W'((RCP_ONE + 64'd1) / 64'd2),
		RCP_W'((RCP_ONE + 64'd6) / 64'd12),
		RCP_W'((RCP_ONE + 64'd15) / 64'd30),
		RCP_W'((RCP_ONE + 64'd28) / 64'd56),
		RCP_W'((RCP_ONE + 64'd45) / 64'd90),
		RCP_W'((RCP_ONE + 64'd66) / 64'd132),
		RCP_W'((RCP_ONE + 64'd91) / 64'd182),
		RCP_W'((RCP_ONE + 64'd120) / 64'd240),
		RCP_W'((RCP_ONE + 64'd153) / 64'd306),
		RCP_W'((RCP_ONE + 64'd190) / 64'd380),
		RCP_W'((RCP_ONE + 64'd231) / 64'd462),
		RCP_W'((RCP_ONE + 64'd276) / 64'd552),
		RCP_W'((RCP_ONE + 64'd325) / 64'd650),
		RCP_W'((RCP_ONE + 64'd378) / 64'd756),
		RCP_W'((RCP_ONE + 64'd435) / 64'd870),
		RCP_W'((RCP_ONE + 64'd496) / 64'd992),
		RCP_W'((RCP_ONE + 64'd561) / 64'd1122),
		RCP_W'((RCP_ONE + 64'd630) / 64'd1260),
		RCP_W'((RCP_ONE + 64'd703) / 64'd1406),
		RCP_W'((RCP_ONE + 64'd780) / 64'd1560)
	};

	typedef struct packed {
		logic vld;
		logic [XSQ_W-1:0] xsq;
		logic [MAG_W-1:0] mag;
		logic signed [SUM_W-1:0] sum;
	} link_t;

endpackage

### design/tcs_front.sv
// Front end: angle conversion, sine offset, range reduction and squaring.
// Five pipeline stages feeding the first series cell.
// Depends on tcs_pkg.
module tcs_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic signed [tcs_pkg::ANGLE_W-1:0] angle,
	input logic func,
	output tcs_pkg::link_t dout
);
	import tcs_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [X_W-1:0] x_s1, x_s2;
	logic [XM_W-1:0] xmag_s3;
	logic [XM_W+XMH_W-1:0] pa_s4, pb_s4;
	logic [2*XM_W-1:0] sq_full;
	logic [XSQ_W-1:0] xsq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign sq_full = {pb_s4, {XMH_W{1'b0}}} + {{XMH_W{1'b0}}, pa_s4};

	always_ff @(posedge clk) begin
		x_s1 <= (X_W'(angle) <<< ANG_SHIFT) - (func ? HALF_PI_Q40 : X_W'(0));
		if (x_s1 >= PI_Q40) begin
			x_s2 <= x_s1 - TWO_PI_Q40;
		end else if (x_s1 < NEG_THREE_PI_Q40) begin
			x_s2 <= x_s1 + FOUR_PI_Q40;
		end else if (x_s1 < NEG_PI_Q40) begin
			x_s2 <= x_s1 + TWO_PI_Q40;
		end else begin
			x_s2 <= x_s1;
		end
		xmag_s3 <= x_s2[X_W-1] ? XM_W'(-x_s2) : XM_W'(x_s2);
		pa_s4 <= (XM_W+XMH_W)'(xmag_s3) * (XM_W+XMH_W)'(xmag_s3[XMH_W-1:0]);
		pb_s4 <= (XM_W+XMH_W)'(xmag_s3) * (XM_W+XMH_W)'(xmag_s3[XM_W-1:XMH_W]);
		xsq_s5 <= sq_full[FRAC +: XSQ_W];
	end

	assign dout.vld = v_s5;
	assign dout.xsq = xsq_s5;
	assign dout.mag = ONE_MAG;
	assign dout.sum = '0;

endmodule

### design/tcs_cell.sv
// One series cell: adds the incoming term to the running sum and forms the
// next term magnitude as term * x^2 * reciprocal, over four stages.
// Depends on tcs_pkg.
module tcs_cell (
	input logic clk,
	input logic arst_n,
	input tcs_pkg::link_t din,
	input logic [tcs_pkg::RCP_W-1:0] recip,
	input logic term_neg,
	output tcs_pkg::link_t dout
);
	import tcs_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [XSQ_W-1:0] xsq_s1, xsq_s2, xsq_s3, xsq_s4;
	logic signed [SUM_W-1:0] sum_s1, sum_s2, sum_s3, sum_s4;
	logic signed [SUM_W-1:0] term;
	logic [MAG_W+XH_W-1:0] pa_s1, pb_s1;
	logic [MAG_W+XSQ_W-1:0] prod1;
	logic [U_W-1:0] u_s2;
	logic [U_W+RH_W-1:0] qa_s3, qb_s3;
	logic [U_W+RCP_W-1:0] prod2;
	logic [MAG_W-1:0] mag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= din.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign term = SUM_W'(din.mag);
	assign prod1 = {pb_s1, {XH_W{1'b0}}} + {{XH_W{1'b0}}, pa_s1};
	assign prod2 = {qb_s3, {RH_W{1'b0}}} + {{RH_W{1'b0}}, qa_s3};

	always_ff @(posedge clk) begin
		sum_s1 <= term_neg ? (din.sum - term) : (din.sum + term);
		xsq_s1 <= din.xsq;
		pa_s1 <= (MAG_W+XH_W)'(din.mag) * (MAG_W+XH_W)'(din.xsq[XH_W-1:0]);
		pb_s1 <= (MAG_W+XH_W)'(din.mag) * (MAG_W+XH_W)'(din.xsq[XSQ_W-1:XH_W]);
		sum_s2 <= sum_s1;
		xsq_s2 <= xsq_s1;
		u_s2 <= prod1[FRAC +: U_W];
		sum_s3 <= sum_s2;
		xsq_s3 <= xsq_s2;
		qa_s3 <= (U_W+RH_W)'(u_s2) * (U_W+RH_W)'(recip[RH_W-1:0]);
		qb_s3 <= (U_W+RH_W)'(u_s2) * (U_W+RH_W)'(recip[RCP_W-1:RH_W]);
		sum_s4 <= sum_s3;
		xsq_s4 <= xsq_s3;
		mag_s4 <= prod2[FRAC +: MAG_W];
	end

	assign dout.vld = v_s4;
	assign dout.xsq = xsq_s4;
	assign dout.mag = mag_s4;
	assign dout.sum = sum_s4;

endmodule

### design/tcs_out.sv
// Output stage: adds the last term, truncates Q.40 to Q1.30 toward zero
// and saturates to plus or minus one. Depends on tcs_pkg.
module tcs_out (
	input logic clk,
	input logic arst_n,
	input tcs_pkg::link_t din,
	output logic signed [tcs_pkg::VAL_W-1:0] value,
	output logic done
);
	import tcs_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic signed [SUM_W-1:0] term;
	logic signed [SUM_W-1:0] s_s1;
	logic [SUM_W-1:0] s_abs;
	logic [SH_W-1:0] s_shift;
	logic [R_W-1:0] r_s2;
	logic neg_s2;
	logic signed [VAL_W-1:0] value_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= din.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign term = SUM_W'(din.mag);
	assign s_abs = s_s1[SUM_W-1] ? SUM_W'(-s_s1) : SUM_W'(s_s1);
	assign s_shift = s_abs[SUM_W-1:OUT_SHIFT];

	always_ff @(posedge clk) begin
		s_s1 <= LAST_NEG ? (din.sum - term) : (din.sum + term);
		r_s2 <= (s_shift > VAL_MAX) ? R_W'(VAL_MAX) : s_shift[R_W-1:0];
		neg_s2 <= s_s1[SUM_W-1];
		value_s3 <= neg_s2 ? -VAL_W'(r_s2) : VAL_W'(r_s2);
	end

	assign value = value_s3;
	assign done = v_s3;

endmodule

### design/taylor_cosine_sine_top.sv
// Top level of the Taylor-series cosine and sine block.
// Instantiates tcs_front, a row of tcs_cell and tcs_out. Depends on tcs_pkg.

// A request is taken on every cycle in which start is high; busy is always low, so a new angle
// may follow in each cycle. The result comes out on value with a one-cycle done pulse after
// its request has passed the 5 front stages, 4 stages per series cell over 15 cells, and 3
// output stages, in request order; the receiver must take it in that cycle. Most of the
// pipeline is the cell row, one four-stage cell per term but the last, which tcs_out adds,
// with every multiplier split into registered partial products.
module taylor_cosine_sine_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [tcs_pkg::ANGLE_W-1:0] angle,
	input logic func,
	output logic signed [tcs_pkg::VAL_W-1:0] value,
	output logic done
);
	import tcs_pkg::*;

	link_t chain [N_CELLS+1];
	logic take;

	assign busy = 1'b0;
	assign take = start && !busy;

	tcs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.angle(angle),
		.func(func),
		.dout(chain[0])
	);

	for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
		tcs_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.din(chain[k]),
			.recip(RECIP_TAB[k]),
			.term_neg(1'((k % 2) == 1)),
			.dout(chain[k+1])
		);
	end

	tcs_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.din(chain[N_CELLS]),
		.value(value),
		.done(done)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##LATENCY done)
		else $error("request did not produce a result after the pipeline latency");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, LATENCY))
		else $error("result strobe without a matching request");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((value <= 32'sd1073741824) && (value >= -32'sd1073741824)))
		else $error("result outside the saturation range");
`endif

endmodule
